// ----- sv/group_by_key_aggregator_top_macros.svh -----
// Assertion macros shared by the aggregator RTL.
// GBKA_ASSERT checks a property on every clock edge outside reset.
// GBKA_ASSERT_NEXT checks that a condition holds in the cycle after a trigger.
`ifndef GROUP_BY_KEY_AGGREGATOR_TOP_MACROS_SVH
`define GROUP_BY_KEY_AGGREGATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GBKA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GBKA_ASSERT_NEXT(lbl, ante, cons, msg) \
    `GBKA_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define GBKA_ASSERT(lbl, prop, msg)
`define GBKA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/gbka_pkg.sv -----
package gbka_pkg;

    // table geometry
    localparam int MAX_GROUPS  = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int INDEX_WIDTH = 16;

    // fixed port field widths
    localparam int KEY_IN_W   = 32;
    localparam int BYTES_W    = 32;
    localparam int SUM_W      = 32;
    localparam int OUT_GIDX_W = 6;
    localparam int OUT_IDX_W  = 16;

    // derived widths
    localparam int GRP_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W = $clog2(MAX_GROUPS + 1);
    localparam int KEY_W = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_HIT,
        OP_NEW,
        OP_FULL
    } t_op_kind;

    typedef enum logic {
        BK_IDLE,
        BK_CALC
    } t_back_state;

    // one classified touch, front to back
    typedef struct packed {
        t_op_kind               kind;
        logic [GRP_W-1:0]       gidx;
        logic [INDEX_WIDTH-1:0] now;
        logic [BYTES_W-1:0]     size;
        logic                   rd;
        logic                   wr;
    } t_op;

    // per-group accumulators held in the back-end memory
    typedef struct packed {
        logic [INDEX_WIDTH-1:0] first;
        logic [INDEX_WIDTH-1:0] last;
        logic [SUM_W-1:0]       touched;
        logic [SUM_W-1:0]       rsum;
        logic [SUM_W-1:0]       wsum;
    } t_entry;

    // one result transfer
    typedef struct packed {
        logic [OUT_GIDX_W-1:0] group_id;
        logic                  new_group;
        logic                  table_full;
        logic [OUT_IDX_W-1:0]  first_touch;
        logic [OUT_IDX_W-1:0]  last_touch;
        logic [SUM_W-1:0]      sum_touched;
        logic [SUM_W-1:0]      sum_read;
        logic [SUM_W-1:0]      sum_written;
    } t_result;

    // queue handshake, both directions
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- sv/gbka_queue.sv -----
module gbka_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  gbka_pkg::t_op         i_push_op,
    input  logic                  i_pop,
    output gbka_pkg::t_op         o_pop_op,
    output gbka_pkg::t_queue_status o_status
);
    import gbka_pkg::*;

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] res;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_push_op;
        end
    end

    assign o_pop_op       = r_slot[r_rptr];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ----- sv/gbka_front.sv -----
`include "group_by_key_aggregator_top_macros.svh"

module gbka_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_start_set,
    input  logic [gbka_pkg::KEY_IN_W-1:0]  i_key,
    input  logic [gbka_pkg::BYTES_W-1:0]   i_size_bytes,
    input  logic                           i_reads,
    input  logic                           i_writes,
    input  gbka_pkg::t_queue_status        i_q_status,
    output logic                           o_push,
    output gbka_pkg::t_op                  o_op
);
    import gbka_pkg::*;

    // key CAM: one register per group, all compared at once
    logic [KEY_W-1:0]       r_keys [MAX_GROUPS];
    logic [CNT_W-1:0]       r_used, n_used;
    logic [INDEX_WIDTH-1:0] r_touch, n_touch;

    logic [KEY_W-1:0]       w_key;
    logic [CNT_W-1:0]       w_eff_used;
    logic [INDEX_WIDTH-1:0] w_now;
    logic [MAX_GROUPS-1:0]  w_match;
    logic [GRP_W-1:0]       w_hit_idx;
    logic                   w_hit;
    logic                   w_full;
    logic                   w_push;
    t_op                    w_op;

    assign w_key      = i_key[KEY_W-1:0];
    assign w_eff_used = i_start_set ? '0 : r_used;
    assign w_now      = i_start_set ? '0 : r_touch;

    always_comb begin
        w_hit_idx = '0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            w_match[g] = (CNT_W'(g) < w_eff_used) && (r_keys[g] == w_key);
            if (w_match[g]) begin
                w_hit_idx = w_hit_idx | GRP_W'(g);
            end
        end
    end

    assign w_hit  = |w_match;
    assign w_full = (w_eff_used == CNT_W'(MAX_GROUPS));
    assign w_push = i_in_valid && !i_q_status.full;

    always_comb begin
        w_op.now  = w_now;
        w_op.size = (i_size_bytes == '1) ? '0 : i_size_bytes;
        w_op.rd   = i_reads;
        w_op.wr   = i_writes;
        priority if (w_hit) begin
            w_op.kind = OP_HIT;
            w_op.gidx = w_hit_idx;
        end else if (w_full) begin
            w_op.kind = OP_FULL;
            w_op.gidx = '0;
        end else begin
            w_op.kind = OP_NEW;
            w_op.gidx = w_eff_used[GRP_W-1:0];
        end
    end

    always_comb begin
        n_used  = r_used;
        n_touch = r_touch;
        if (w_push) begin
            n_touch = w_now + 1'b1;
            n_used  = (w_op.kind == OP_NEW) ? w_eff_used + 1'b1 : w_eff_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_touch <= '0;
        end else begin
            r_used  <= n_used;
            r_touch <= n_touch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && w_op.kind == OP_NEW) begin
            r_keys[w_eff_used[GRP_W-1:0]] <= w_key;
        end
    end

    assign o_in_stall = i_q_status.full;
    assign o_push     = w_push;
    assign o_op       = w_op;

    // keys stay unique, so at most one entry can hit
    `GBKA_ASSERT(a_match_unique, $onehot0(w_match), "key matched more than one group")
    `GBKA_ASSERT_NEXT(a_used_grows, w_push && w_op.kind == OP_NEW, r_used == CNT_W'($past(w_eff_used) + 1'b1), "group count did not advance on a new group")
    `GBKA_ASSERT(a_used_bounded, r_used <= CNT_W'(MAX_GROUPS), "group count beyond table size")

endmodule

// ----- sv/gbka_back.sv -----
`include "group_by_key_aggregator_top_macros.svh"

module gbka_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gbka_pkg::t_queue_status i_q_status,
    input  gbka_pkg::t_op           i_op,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output gbka_pkg::t_result       o_res
);
    import gbka_pkg::*;

    t_entry        r_mem [MAX_GROUPS];
    t_entry        r_rdata;
    t_op           r_op;
    t_back_state   r_state, n_state;
    logic          r_out_valid, n_out_valid;
    t_result       r_res;

    logic          w_slot_free;
    logic          w_load;
    logic          w_mem_we;
    t_entry        w_wdata;
    t_result       w_res;
    logic [SUM_W-1:0] w_rd_add;
    logic [SUM_W-1:0] w_wr_add;

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_CALC;
                end
            end
            BK_CALC: begin
                if (w_slot_free) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign w_rd_add = r_op.rd ? r_op.size : '0;
    assign w_wr_add = r_op.wr ? r_op.size : '0;

    always_comb begin
        w_wdata.first   = r_op.now;
        w_wdata.last    = r_op.now;
        w_wdata.touched = r_op.size;
        w_wdata.rsum    = w_rd_add;
        w_wdata.wsum    = w_wr_add;
        if (r_op.kind == OP_HIT) begin
            w_wdata.first   = r_rdata.first;
            w_wdata.touched = r_rdata.touched + r_op.size;
            w_wdata.rsum    = r_rdata.rsum + w_rd_add;
            w_wdata.wsum    = r_rdata.wsum + w_wr_add;
        end
    end

    always_comb begin
        w_res.group_id    = OUT_GIDX_W'(r_op.gidx);
        w_res.new_group   = (r_op.kind == OP_NEW);
        w_res.table_full  = 1'b0;
        w_res.first_touch = OUT_IDX_W'(w_wdata.first);
        w_res.last_touch  = OUT_IDX_W'(w_wdata.last);
        w_res.sum_touched = w_wdata.touched;
        w_res.sum_read    = w_wdata.rsum;
        w_res.sum_written = w_wdata.wsum;
        if (r_op.kind == OP_FULL) begin
            w_res            = '0;
            w_res.table_full = 1'b1;
        end
    end

    assign w_mem_we = w_load && (r_op.kind != OP_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op    <= i_op;
            r_rdata <= r_mem[i_op.gidx];
        end
        if (w_mem_we) begin
            r_mem[r_op.gidx] <= w_wdata;
        end
        if (w_load) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    `GBKA_ASSERT(a_pop_nonempty, o_pop |-> !i_q_status.empty, "popped an empty queue")
    `GBKA_ASSERT(a_valid_from_calc, $rose(r_out_valid) |-> $past(r_state) == BK_CALC, "result raised outside the update step")
    `GBKA_ASSERT_NEXT(a_full_zeroes, w_load && r_op.kind == OP_FULL, r_res.sum_touched == '0 && r_res.first_touch == '0 && r_res.table_full, "table-full result not cleared")
    `GBKA_ASSERT_NEXT(a_new_first_last, w_load && r_op.kind == OP_NEW, r_res.first_touch == r_res.last_touch && r_res.new_group, "new group with differing first and last")

endmodule

// ----- sv/group_by_key_aggregator_top.sv -----
// Groups a stream of memory touches by a precomputed key. Every accepted
// touch yields exactly one result transfer: the group it fell into (groups
// numbered by first appearance, up to 64), whether it opened that group,
// whether the table was full, the group's first and latest touch index and
// its wrapping 32-bit totals of touched, read and written bytes. A byte count
// of all ones counts as zero; start_set clears the table and makes this touch
// index zero. A front end compares the key against all stored keys at once
// and hands a classified op to a two-entry queue; a back end then reads
// the group's accumulators from a single-port memory, updates them and writes
// them back, finishing one touch before it pops the next; the read-then-write
// path of the accumulator memory sets the sustained rate.
// No clearing pass is needed after reset: the group count masks stale entries.

module group_by_key_aggregator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // touch channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_start_set,
    input  logic [gbka_pkg::KEY_IN_W-1:0]   i_key,
    input  logic [gbka_pkg::BYTES_W-1:0]    i_size_bytes,
    input  logic                            i_reads,
    input  logic                            i_writes,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gbka_pkg::OUT_GIDX_W-1:0] o_group_id,
    output logic                            o_new_group,
    output logic                            o_table_full,
    output logic [gbka_pkg::OUT_IDX_W-1:0]  o_first_touch,
    output logic [gbka_pkg::OUT_IDX_W-1:0]  o_last_touch,
    output logic [gbka_pkg::SUM_W-1:0]      o_sum_touched,
    output logic [gbka_pkg::SUM_W-1:0]      o_sum_read,
    output logic [gbka_pkg::SUM_W-1:0]      o_sum_written
);
    import gbka_pkg::*;

    t_queue_status w_q_status;
    logic          w_push;
    logic          w_pop;
    t_op           w_push_op;
    t_op           w_pop_op;
    t_result       w_res;

    // Front: key match, group allocation and touch index. Owns the key store
    // and group count, so classification never waits on the back end.
    gbka_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_start_set  (i_start_set),
        .i_key        (i_key),
        .i_size_bytes (i_size_bytes),
        .i_reads      (i_reads),
        .i_writes     (i_writes),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_op         (w_push_op)
    );

    // Decouples the two halves; input stalls only when it is full.
    gbka_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_op (w_push_op),
        .i_pop     (w_pop),
        .o_pop_op  (w_pop_op),
        .o_status  (w_q_status)
    );

    // Back: accumulator read-modify-write and the output register. Ops run
    // strictly in order, one at a time, so no forwarding is needed.
    gbka_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_op        (w_pop_op),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_res)
    );

    assign o_group_id    = w_res.group_id;
    assign o_new_group   = w_res.new_group;
    assign o_table_full  = w_res.table_full;
    assign o_first_touch = w_res.first_touch;
    assign o_last_touch  = w_res.last_touch;
    assign o_sum_touched = w_res.sum_touched;
    assign o_sum_read    = w_res.sum_read;
    assign o_sum_written = w_res.sum_written;

endmodule

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gbka_pkg::*;

    // Byte count that means "size unknown"; it adds nothing to any total.
    localparam logic [BYTES_W-1:0] UNKNOWN_BYTES = '1;
    // Run limit in ns: far beyond the slowest legal run.
    localparam int RUN_LIMIT_NS = 800_000;
    // Cycles to wait after the last result for any stray transfer.
    localparam int SETTLE_CYCLES = 16;
    // Odd multiplier: i * GOLDEN is a bijection mod 2^32, so keys stay distinct.
    localparam logic [KEY_IN_W-1:0] GOLDEN = 32'h9E37_79B9;

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  i_start_set  = 1'b0;
    logic [KEY_IN_W-1:0]   i_key        = '0;
    logic [BYTES_W-1:0]    i_size_bytes = '0;
    logic                  i_reads      = 1'b0;
    logic                  i_writes     = 1'b0;
    logic                  i_out_stall  = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [OUT_GIDX_W-1:0] o_group_id;
    logic                  o_new_group;
    logic                  o_table_full;
    logic [OUT_IDX_W-1:0]  o_first_touch;
    logic [OUT_IDX_W-1:0]  o_last_touch;
    logic [SUM_W-1:0]      o_sum_touched;
    logic [SUM_W-1:0]      o_sum_read;
    logic [SUM_W-1:0]      o_sum_written;

    group_by_key_aggregator_top dut (.*);

    // ------------------------------------------------------------------
    // Predicted group table. Only entries below groups_open are ever read,
    // so the never-written tail of each array stays out of the picture.
    // ------------------------------------------------------------------
    logic [KEY_IN_W-1:0]    grp_key     [MAX_GROUPS];
    logic [INDEX_WIDTH-1:0] grp_first   [MAX_GROUPS];
    logic [INDEX_WIDTH-1:0] grp_last    [MAX_GROUPS];
    logic [SUM_W-1:0]       grp_touched [MAX_GROUPS];
    logic [SUM_W-1:0]       grp_read    [MAX_GROUPS];
    logic [SUM_W-1:0]       grp_written [MAX_GROUPS];
    int                     groups_open = 0;
    logic [INDEX_WIDTH-1:0] next_touch  = '0;   // wraps mod 2^INDEX_WIDTH

    t_result pending_results[$];   // predicted results, oldest first
    int      mismatches    = 0;
    int      send_idle_pct = 0;    // chance (in %) the sender skips a cycle
    int      recv_idle_pct = 0;    // chance (in %) the receiver stalls a cycle
    logic    out_hold      = 1'b0; // long receiver hold-off in progress

    // Applies one touch to the predicted table and returns its result.
    function automatic t_result aggregate_touch(logic start, logic [KEY_IN_W-1:0] key,
                                                logic [BYTES_W-1:0] nbytes,
                                                logic rd, logic wr);
        t_result                r;
        logic [BYTES_W-1:0]     bytes;
        logic [INDEX_WIDTH-1:0] idx;
        int                     g;
        bit                     hit;
        r = '0;
        if (start) begin
            groups_open = 0;
            next_touch  = '0;
        end
        idx        = next_touch;
        next_touch = next_touch + 1'b1;
        bytes      = (nbytes == UNKNOWN_BYTES) ? '0 : nbytes;
        hit        = 1'b0;
        g          = 0;
        for (int j = 0; j < groups_open; j++) begin
            if (!hit && grp_key[j] == key) begin
                hit = 1'b1;
                g   = j;
            end
        end
        if (hit) begin
            grp_last[g]    = idx;
            grp_touched[g] = grp_touched[g] + bytes;
            if (rd) grp_read[g]    = grp_read[g] + bytes;
            if (wr) grp_written[g] = grp_written[g] + bytes;
        end else if (groups_open < MAX_GROUPS) begin
            g              = groups_open;
            groups_open    = groups_open + 1;
            grp_key[g]     = key;
            grp_first[g]   = idx;
            grp_last[g]    = idx;
            grp_touched[g] = bytes;
            grp_read[g]    = rd ? bytes : '0;
            grp_written[g] = wr ? bytes : '0;
            r.new_group    = 1'b1;
        end else begin
            // table full: key dropped, index still consumed, rest of result zero
            r.table_full = 1'b1;
            return r;
        end
        r.group_id    = OUT_GIDX_W'(g);
        r.first_touch = grp_first[g];
        r.last_touch  = grp_last[g];
        r.sum_touched = grp_touched[g];
        r.sum_read    = grp_read[g];
        r.sum_written = grp_written[g];
        return r;
    endfunction

    // Byte counts weighted toward the interesting ones: unknown, near wrap,
    // fully random and small.
    function automatic logic [BYTES_W-1:0] pick_byte_count();
        case ($urandom_range(9))
            0:       return UNKNOWN_BYTES;
            1:       return UNKNOWN_BYTES - 1 - $urandom_range(255);
            2, 3:    return $urandom;
            default: return $urandom_range(4096);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Touch sender: optional idle cycles, then holds the touch until the
    // edge that transfers it. Valid stays high across back-to-back touches.
    // ------------------------------------------------------------------
    task automatic send_touch(logic start, logic [KEY_IN_W-1:0] key,
                              logic [BYTES_W-1:0] nbytes, logic rd, logic wr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_set  <= start;
        i_key        <= key;
        i_size_bytes <= nbytes;
        i_reads      <= rd;
        i_writes     <= wr;
        // values read right after the edge are the ones the DUT saw at it
        do @(posedge i_clk); while (o_in_stall);
        pending_results.insert(pending_results.size(),
                               aggregate_touch(start, key, nbytes, rd, wr));
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall plus an optional long hold-off.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= out_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{group_id: o_group_id, new_group: o_new_group,
                    table_full: o_table_full, first_touch: o_first_touch,
                    last_touch: o_last_touch, sum_touched: o_sum_touched,
                    sum_read: o_sum_read, sum_written: o_sum_written};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none pending: group %0d new %b full %b",
                             $realtime, got.group_id, got.new_group, got.table_full);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result mismatch", $realtime);
                        $display("  exp grp %0d new %b full %b first %0d last %0d tch %h rd %h wr %h",
                                 want.group_id, want.new_group, want.table_full,
                                 want.first_touch, want.last_touch, want.sum_touched,
                                 want.sum_read, want.sum_written);
                        $display("  got grp %0d new %b full %b first %0d last %0d tch %h rd %h wr %h",
                                 got.group_id, got.new_group, got.table_full,
                                 got.first_touch, got.last_touch, got.sum_touched,
                                 got.sum_read, got.sum_written);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, unknown size, total wrap, every flag mix, set restart.
    task automatic run_directed_corners();
        send_touch(1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        send_touch(1'b0, 32'hFFFF_FFFF, UNKNOWN_BYTES,  1'b1, 1'b1);  // counts as zero
        send_touch(1'b0, 32'h0000_0000, 32'hFFFF_FFFE, 1'b1, 1'b0);
        send_touch(1'b0, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 1'b1);
        send_touch(1'b0, 32'h0000_0000, 32'h0000_0005, 1'b1, 1'b1);  // touched wraps
        send_touch(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0);  // touched only
        send_touch(1'b0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
        send_touch(1'b0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);  // all wrap to 0
        send_touch(1'b0, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b1);
        send_touch(1'b0, 32'h7FFF_FFFF, UNKNOWN_BYTES,  1'b1, 1'b0);
        send_touch(1'b0, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b1);
        // restart: an old key opens group 0 again at touch index 0
        send_touch(1'b1, 32'hFFFF_FFFF, 32'h0000_1234, 1'b1, 1'b0);
        send_touch(1'b0, 32'h0000_0000, 32'h0000_0010, 1'b1, 1'b1);
        send_touch(1'b1, 32'h0000_0000, 32'h0000_0020, 1'b0, 1'b1);  // back-to-back start
        send_touch(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_touch(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1);
        send_touch(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0);
    endtask

    // Fill all groups, then new keys are flagged full while hits still update.
    task automatic run_table_full();
        logic [KEY_IN_W-1:0] salt;
        salt = $urandom;
        for (int i = 0; i < MAX_GROUPS; i++)
            send_touch(i == 0, (i * GOLDEN) ^ salt, pick_byte_count(), i[0], i[1]);
        for (int i = MAX_GROUPS; i < MAX_GROUPS + 4; i++)
            send_touch(1'b0, (i * GOLDEN) ^ salt, pick_byte_count(), 1'b1, 1'b1);
        send_touch(1'b0, salt, 32'h0000_0100, 1'b1, 1'b0);                          // group 0
        send_touch(1'b0, ((MAX_GROUPS - 1) * GOLDEN) ^ salt, 32'h200, 1'b0, 1'b1);  // last group
        send_touch(1'b0, (MAX_GROUPS * GOLDEN) ^ salt, 32'h0000_0300, 1'b0, 1'b0);  // still full
        // a start clears the full table; the dropped key now gets group 0
        send_touch(1'b1, (MAX_GROUPS * GOLDEN) ^ salt, 32'h0000_0400, 1'b1, 1'b1);
    endtask

    // Random sets: each usually opens with a start and draws keys from a pool
    // whose size ranges from a single key to more than the table holds.
    task automatic run_random_sets(int n_items);
        logic [KEY_IN_W-1:0] pool [MAX_GROUPS + 30];
        logic [KEY_IN_W-1:0] key;
        int                  sent;
        int                  set_len;
        int                  pool_size;
        sent = 0;
        while (sent < n_items) begin
            set_len = $urandom_range(1, 120);
            case ($urandom_range(3))
                0:       pool_size = $urandom_range(1, 4);
                1:       pool_size = $urandom_range(5, 40);
                2:       pool_size = MAX_GROUPS;
                default: pool_size = $urandom_range(MAX_GROUPS + 1, MAX_GROUPS + 30);
            endcase
            for (int i = 0; i < pool_size; i++)
                pool[i] = $urandom;
            for (int i = 0; i < set_len && sent < n_items; i++) begin
                // mostly pooled keys; a few stray keys and stray starts as noise
                key = ($urandom_range(19) == 0) ? $urandom : pool[$urandom_range(pool_size - 1)];
                send_touch((i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0),
                           key, pick_byte_count(), $urandom_range(1), $urandom_range(1));
                sent++;
            end
        end
    endtask

    // Receiver holds off long enough for the block to fill and stall its
    // input, then the sender pauses until every result is back.
    task automatic run_backpressure();
        fork
            begin
                out_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                out_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            send_touch(i == 0, $urandom_range(7), pick_byte_count(),
                       $urandom_range(1), $urandom_range(1));
        wait_all_results();
        for (int i = 0; i < 10; i++)
            send_touch(1'b0, $urandom_range(7), pick_byte_count(),
                       $urandom_range(1), $urandom_range(1));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 67;
        run_directed_corners();
        run_table_full();
        run_random_sets(250);

        send_idle_pct = 67;
        recv_idle_pct = 28;
        run_random_sets(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_sets(250);
        run_backpressure();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- group_by_key_aggregator_top.f -----
+incdir+sv
sv/gbka_pkg.sv
sv/gbka_queue.sv
sv/gbka_front.sv
sv/gbka_back.sv
sv/group_by_key_aggregator_top.sv
bench/testbench.sv
